[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/tsi_pkg.sv]
// Types, constants and codes of the telemetry sample interpolator.
package tsi_pkg;

	localparam int CHANNEL_COUNT = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_W = 36;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [31:0] TWO_PI_Q = 32'd411775;
	localparam logic [35:0] WRAP_OFS = 36'd6746521600;
	localparam logic [35:0] RECIP_NUM = 36'd65536000000;
	localparam logic [25:0] RATE_MAX = 26'h3FFFFFF;
	localparam logic [16:0] ONE_Q = 17'd65536;

	// Products at or above this give a blend factor above one.
	localparam logic [35:0] FACTOR_CLAMP = 36'd65537000000;
	// ceil(2^44 / 15625): exact quotient by 15625 for 30-bit dividends.
	localparam logic [30:0] FACTOR_RECIP = 31'd1125899907;
	// floor(2^42 / TWO_PI_Q): quotient estimate from the top 24 of 34 bits.
	localparam logic [23:0] WRAP_RECIP = 24'd10680703;

	localparam logic [19:0] MIN_INTERVAL_RST = 20'd1000;
	localparam logic [23:0] STALE_INTERVAL_RST = 24'd250000;

	localparam logic [0:0] REG_MIN_INTERVAL = 1'd0;
	localparam logic [0:0] REG_STALE_INTERVAL = 1'd1;

	localparam logic [1:0] KIND_FEED = 2'd0;
	localparam logic [1:0] KIND_LINEAR = 2'd1;
	localparam logic [1:0] KIND_ANGLE_POS = 2'd2;
	localparam logic [1:0] KIND_ANGLE_SYM = 2'd3;

	typedef enum logic [1:0] {OP_FEED, OP_LIN, OP_ANG_POS, OP_ANG_SYM} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] channel;
		logic signed [31:0] sample_value;
		logic [31:0] now_us;
	} in_t;

	typedef struct packed {
		logic signed [31:0] interpolated_value;
		logic [3:0] channel_echo;
	} out_t;

	typedef struct packed {
		op_t op;
		logic chan_ok;
		logic [3:0] channel;
		logic signed [31:0] sample;
		logic [31:0] now;
	} job_t;

	typedef struct packed {
		logic start;
		logic [DIV_CNT_W-1:0] nbits;
		logic [DIV_W-1:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

endpackage

[rtl/core/telemetry_sample_interpolator_core.sv]
// Top level of the telemetry sample interpolator.
//
// Input channel in_valid/in_stall/in_data carries feed and get beats; output
// channel out_valid/out_stall/out_data carries one result beat per get, none
// per feed. The config port (cfg_we, cfg_index, cfg_data) writes the minimum
// interval (index 0) and the stale interval (index 1); the user must write
// them only while the block is idle, as the block itself does not enforce it.
// Beats pass a one-stage front register and a two-entry queue, then a
// sequential engine that works one item at a time:
//   feed: table update, plus a rate update by a 36-bit serial reciprocal
//   linear get: the factor divide is skipped when stale or the factor clamps
//   angle get: likewise, with two wraps to two pi
// The engine takes a new item only once it is through with the last one.
// Reset clears the channel table, the config registers to their defaults and
// all valid flags. When the receiver stalls, the result waits in the output
// register, the engine holds its next result, and the queue then fills and
// raises in_stall.
module telemetry_sample_interpolator_core import tsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic fr_valid, q_full, q_pop, q_avail;
	job_t fr_job, q_job;

	tsi_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .job_valid(fr_valid), .job_full(q_full), .job(fr_job)
	);

	tsi_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(fr_valid), .push_data(fr_job), .full(q_full),
		.pop(q_pop), .not_empty(q_avail), .pop_data(q_job)
	);

	tsi_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .job_avail(q_avail), .job(q_job), .job_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

[rtl/core/tsi_front.sv]
// Front end: takes input beats, classifies them and hands them to the queue.
module tsi_front import tsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic job_valid,
	input  logic job_full,
	output job_t job
);

	logic valid_s1;
	job_t job_s1;
	op_t  op_w;

	always_comb begin
		unique case (in_data.kind)
			KIND_FEED:      op_w = OP_FEED;
			KIND_LINEAR:    op_w = OP_LIN;
			KIND_ANGLE_POS: op_w = OP_ANG_POS;
			default:        op_w = OP_ANG_SYM;
		endcase
	end

	assign in_stall = valid_s1 && job_full;
	assign job_valid = valid_s1;
	assign job = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			job_s1.op <= op_w;
			job_s1.chan_ok <= (32'(in_data.channel) < CHANNEL_COUNT);
			job_s1.channel <= in_data.channel;
			job_s1.sample <= in_data.sample_value;
			job_s1.now <= in_data.now_us;
		end
	end

endmodule

[rtl/core/tsi_fifo.sv]
// Short queue of classified jobs between the front end and the engine.
module tsi_fifo import tsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

[rtl/core/tsi_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module tsi_div import tsi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] num_q, quo_q;
	logic [31:0] rem_q, den_q;
	logic [32:0] trial_w;
	logic fits_w;

	// The numerator is left aligned, so its top bit enters the remainder each step.
	assign trial_w = {rem_q, num_q[DIV_W-1]};
	assign fits_w = (trial_w >= {1'b0, den_q});

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], fits_w};
			rem_q <= fits_w ? 32'(trial_w - {1'b0, den_q}) : trial_w[31:0];
		end
	end

endmodule

[rtl/core/tsi_back.sv]
// Engine: channel table, feed updates, blend arithmetic and the output register.
module tsi_back import tsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        job_avail,
	input  job_t        job,
	output logic        job_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_FDIV, S_GMUL, S_GDIV, S_GDIFF, S_GWRAP1,
		S_GBLEND, S_GSUM, S_GWRAP2, S_OUT
	} state_t;

	state_t state_q;
	job_t job_q;
	logic [19:0] min_int_q;
	logic [23:0] stale_int_q;

	logic signed [31:0] prev_q [CHANNEL_COUNT];
	logic signed [31:0] cur_q [CHANNEL_COUNT];
	logic [31:0] time_q [CHANNEL_COUNT];
	logic [25:0] rate_q [CHANNEL_COUNT];
	logic [CHANNEL_COUNT-1:0] stale_q, fed_q;

	logic signed [31:0] p_q, q_q, res_q;
	logic st_q;
	logic [57:0] prod_q;
	logic [60:0] fmul_q;
	logic [16:0] f_q;
	logic signed [32:0] d_q;
	logic signed [50:0] mul_q;
	logic [33:0] wy_q;
	logic [1:0] wcnt_q;
	logic [47:0] wmul_q;
	logic [34:0] wqd_q;
	div_req_t div_req_q;
	div_rsp_t div_rsp;
	logic out_valid_q;
	out_t out_data_q;

	logic [31:0] diff_w, floor_w, dfl_w;
	logic [25:0] recip_w;
	logic signed [32:0] dq_w, dwrap_w;
	logic signed [51:0] sum_w;
	logic signed [35:0] r_w;
	logic signed [31:0] rwrap_w;
	logic [35:0] dofs_w, rofs_w;
	logic [33:0] wsub_w;
	logic [31:0] wrap_rem_w;

	tsi_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req_q), .rsp(div_rsp));

	assign job_pop = (state_q == S_IDLE) && job_avail;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		diff_w = job_q.now - time_q[job_q.channel];
		floor_w = (min_int_q == '0) ? 32'd1 : 32'(min_int_q);
		dfl_w = (diff_w < floor_w) ? floor_w : diff_w;
		recip_w = (div_rsp.quo > DIV_W'(RATE_MAX)) ? RATE_MAX : div_rsp.quo[25:0];
		dq_w = 33'(q_q) - 33'(p_q);
		dofs_w = 36'(dq_w) + WRAP_OFS;
		// The quotient estimate is low by at most one, so one subtraction finishes the wrap.
		wsub_w = wy_q - wqd_q[33:0];
		wrap_rem_w = (wsub_w >= 34'(TWO_PI_Q)) ? 32'(wsub_w - 34'(TWO_PI_Q)) : 32'(wsub_w);
		dwrap_w = ({wrap_rem_w, 1'b0} >= 33'(TWO_PI_Q))
			? $signed({1'b0, wrap_rem_w}) - $signed({1'b0, TWO_PI_Q})
			: $signed({1'b0, wrap_rem_w});
		sum_w = $signed({{4{p_q[31]}}, p_q, 16'b0}) + 52'(mul_q) + 52'sd32768;
		r_w = sum_w[51:16];
		rofs_w = 36'(r_w) + WRAP_OFS;
		rwrap_w = (job_q.op == OP_ANG_SYM && {wrap_rem_w, 1'b0} >= 33'(TWO_PI_Q))
			? $signed(wrap_rem_w - TWO_PI_Q) : $signed(wrap_rem_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			min_int_q <= MIN_INTERVAL_RST;
			stale_int_q <= STALE_INTERVAL_RST;
			stale_q <= '0;
			fed_q <= '0;
			out_valid_q <= 1'b0;
			div_req_q <= '0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				prev_q[i] <= '0;
				cur_q[i] <= '0;
				time_q[i] <= '0;
				rate_q[i] <= '0;
			end
		end else begin
			if (div_req_q.start) begin
				div_req_q.start <= 1'b0;
			end
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			// Wrap pipeline: quotient estimate, then its multiple of two pi.
			wmul_q <= wy_q[33:10] * WRAP_RECIP;
			wqd_q <= wmul_q[47:32] * TWO_PI_Q[18:0];
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_INTERVAL:   min_int_q <= cfg_data[19:0];
					REG_STALE_INTERVAL: stale_int_q <= cfg_data;
					default:            ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_avail) begin
						job_q <= job;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					p_q <= prev_q[job_q.channel];
					q_q <= cur_q[job_q.channel];
					st_q <= stale_q[job_q.channel];
					prod_q <= 58'(diff_w) * 58'(rate_q[job_q.channel]);
					if (!job_q.chan_ok) begin
						res_q <= '0;
						state_q <= (job_q.op == OP_FEED) ? S_IDLE : S_OUT;
					end else if (job_q.op == OP_FEED) begin
						prev_q[job_q.channel] <= cur_q[job_q.channel];
						cur_q[job_q.channel] <= job_q.sample;
						time_q[job_q.channel] <= job_q.now;
						if (!fed_q[job_q.channel]) begin
							fed_q[job_q.channel] <= 1'b1;
							stale_q[job_q.channel] <= 1'b1;
							state_q <= S_IDLE;
						end else if (dfl_w > 32'(stale_int_q)) begin
							stale_q[job_q.channel] <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							div_req_q <= '{start: 1'b1, nbits: DIV_CNT_W'(DIV_W),
								num: RECIP_NUM, den: dfl_w};
							state_q <= S_FDIV;
						end
					end else begin
						state_q <= S_GMUL;
					end
				end
				S_FDIV: begin
					if (div_rsp.done) begin
						stale_q[job_q.channel] <= 1'b0;
						rate_q[job_q.channel] <= 26'(({1'b0, rate_q[job_q.channel]}
							+ {1'b0, recip_w}) >> 1);
						state_q <= S_IDLE;
					end
				end
				S_GMUL: begin
					if (st_q || prod_q >= 58'(FACTOR_CLAMP)) begin
						f_q <= ONE_Q;
						state_q <= S_GDIFF;
					end else begin
						// Divide by one million as a shift by 6 and a reciprocal of 15625.
						fmul_q <= prod_q[35:6] * FACTOR_RECIP;
						state_q <= S_GDIV;
					end
				end
				S_GDIV: begin
					f_q <= fmul_q[60:44];
					state_q <= S_GDIFF;
				end
				S_GDIFF: begin
					if (job_q.op == OP_LIN) begin
						d_q <= dq_w;
						state_q <= S_GBLEND;
					end else begin
						wy_q <= dofs_w[33:0];
						wcnt_q <= '0;
						state_q <= S_GWRAP1;
					end
				end
				S_GWRAP1: begin
					if (wcnt_q == 2'd2) begin
						d_q <= dwrap_w;
						state_q <= S_GBLEND;
					end else begin
						wcnt_q <= wcnt_q + 1'b1;
					end
				end
				S_GBLEND: begin
					mul_q <= d_q * $signed({1'b0, f_q});
					state_q <= S_GSUM;
				end
				S_GSUM: begin
					if (job_q.op == OP_LIN) begin
						res_q <= r_w[31:0];
						state_q <= S_OUT;
					end else begin
						wy_q <= rofs_w[33:0];
						wcnt_q <= '0;
						state_q <= S_GWRAP2;
					end
				end
				S_GWRAP2: begin
					if (wcnt_q == 2'd2) begin
						res_q <= rwrap_w;
						state_q <= S_OUT;
					end else begin
						wcnt_q <= wcnt_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_data_q <= '{interpolated_value: res_q, channel_echo: job_q.channel};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/tsi_checker.sv]
// Port-level checker for the interpolator top level, with its bind.
`include "assert_macros.svh"

module tsi_checker import tsi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// A result beat stays offered until it is taken.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))
	// Coming out of reset the block is empty: no result and free to accept.
	`ASSERT_IMPLIES(a_reset_empty, clk, arst_n, !$past(arst_n), !out_valid && !in_stall)

endmodule

bind telemetry_sample_interpolator_core tsi_checker u_tsi_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data)
);
